@@ sv/keyed_table_insert_delete_lookup_defines.svh @@
// assertion macros shared by the checker
`ifndef KEYED_TABLE_INSERT_DELETE_LOOKUP_DEFINES_SVH
`define KEYED_TABLE_INSERT_DELETE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define KT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define KT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/kt_pkg.sv @@
package kt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int SLOT_W      = KEY_W + VAL_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage

@@ sv/keyed_table_insert_delete_lookup.sv @@
// channel  direction  handshake             beat payload
// in       input      in_valid / in_ready   opcode, lookup_key, entry_value
// out      output     out_valid / out_ready status, found_value, entry_count
//
// add and unused opcode: accepted in S_IDLE, then S_FIN loads the result register
// get: scans from the newest slot down to the newest match, one slot read per cycle
// delete: scan as for get, then the slots above the match move down one per cycle by the single-port-pair ram
// reset clears the entry count and the handshake state; slot storage is not cleared
// in_ready is high only when no beat is in progress; a result waits in the output register
module keyed_table_insert_delete_lookup
  import kt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       opcode,
  input  logic [KEY_W-1:0] lookup_key,
  input  logic [VAL_W-1:0] entry_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [VAL_W-1:0] found_value,
  output logic [CNT_W-1:0] entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t              state;
  logic [1:0]          op_q;
  logic [KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;
  status_t             res_status;
  logic [VAL_W-1:0]    res_found;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]   wr_data;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]   rd_data;
  logic [KEY_W-1:0]    rd_key;
  logic [VAL_W-1:0]    rd_val;
  logic [IDX_W-1:0]    scan_addr;
  logic                hit;

  kt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state == S_IDLE) && !rst;
  assign rd_key    = rd_data[SLOT_W-1:VAL_W];
  assign rd_val    = rd_data[VAL_W-1:0];
  assign scan_addr = IDX_W'(ptr - CNT_W'(1));
  assign hit       = pend && (rd_key == key_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = {lookup_key, entry_value};
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    unique case (state)
      S_IDLE: begin
        wr_en = in_valid && in_ready && (opcode == OP_ADD) && (count < CNT_FULL);
      end
      S_SCAN: begin
        rd_en = !hit && (ptr != '0);
      end
      S_SHIFT: begin
        rd_en   = (ptr < count);
        rd_addr = ptr[IDX_W-1:0];
        wr_en   = pend;
        wr_addr = pend_idx - IDX_W'(1);
        wr_data = rd_data;
      end
      S_FIN: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= opcode;
            key_q      <= lookup_key;
            res_found  <= '0;
            res_status <= ((opcode == OP_ADD) && (count >= CNT_FULL)) ? ST_FULL : ST_OK;
            pend       <= 1'b0;
            case (opcode) inside
              OP_ADD: begin
                if (count < CNT_FULL) begin
                  count <= count + CNT_W'(1);
                end
                state <= S_FIN;
              end
              OP_DELETE, OP_GET: begin
                ptr   <= count;
                state <= S_SCAN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            pend <= 1'b0;
            if (op_q == OP_GET) begin
              res_found <= rd_val;
              state     <= S_FIN;
            end else begin
              ptr   <= CNT_W'(pend_idx) + CNT_W'(1);
              state <= S_SHIFT;
            end
          end else if ((ptr == '0) && !pend) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_FIN;
          end else begin
            pend <= (ptr != '0);
            if (ptr != '0) begin
              pend_idx <= scan_addr;
              ptr      <= ptr - CNT_W'(1);
            end
          end
        end
        S_SHIFT: begin
          pend <= rd_en;
          if (rd_en) begin
            pend_idx <= ptr[IDX_W-1:0];
            ptr      <= ptr + CNT_W'(1);
          end else if (!pend) begin
            count <= count - CNT_W'(1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_value <= res_found;
            entry_count <= count;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/kt_ram.sv @@
module kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/kt_checker.sv @@
`include "keyed_table_insert_delete_lookup_defines.svh"

module kt_checker
  import kt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       opcode,
  input logic [KEY_W-1:0] lookup_key,
  input logic [VAL_W-1:0] entry_value,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic [VAL_W-1:0] found_value,
  input logic [CNT_W-1:0] entry_count
);

  // stalled result beat holds
  `KT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_value) && $stable(entry_count))

  `KT_ASSERT_IMPL(a_count_max, clk, rst, out_valid, entry_count <= CNT_FULL)

  `KT_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && (status != ST_OK), found_value == '0)

  `KT_ASSERT_IMPL(a_full_count, clk, rst, out_valid && (status == ST_FULL), entry_count == CNT_FULL)

endmodule

bind keyed_table_insert_delete_lookup kt_checker u_kt_checker (.*);

@@ tb/keyed_table_insert_delete_lookup_test.sv @@
module keyed_table_insert_delete_lookup_test;
  import kt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_entry_t;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } table_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       opcode = OP_ADD;
  logic [KEY_W-1:0] lookup_key = '0;
  logic [VAL_W-1:0] entry_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic [VAL_W-1:0] found_value;
  logic [CNT_W-1:0] entry_count;

  table_entry_t     table_entries[$];
  table_result_t    pending_results[$];
  logic [KEY_W-1:0] key_pool[8];
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               error_count = 0;

  keyed_table_insert_delete_lookup i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // newest match wins for get and delete; entries stay in insertion order
  function automatic void predict_table_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] value);
    table_result_t res;
    table_entry_t  ent;
    int            hit;
    res.status      = ST_OK;
    res.found_value = '0;
    hit = -1;
    for (int i = table_entries.size() - 1; i >= 0; i--) begin
      if (table_entries[i].key == key) begin
        hit = i;
        break;
      end
    end
    case (op)
      OP_ADD: begin
        if (table_entries.size() >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          ent.key   = key;
          ent.value = value;
          table_entries.push_back(ent);
        end
      end
      OP_DELETE: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else table_entries.delete(hit);
      end
      OP_GET: begin
        if (hit < 0) res.status = ST_NOT_FOUND;
        else res.found_value = table_entries[hit].value;
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(table_entries.size());
    pending_results.push_back(res);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // mostly keys that are live or recur, so lookups and deletes hit
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && table_entries.size() > 0)
      return table_entries[$urandom_range(table_entries.size() - 1)].key;
    if (r < 75) return key_pool[$urandom_range(7)];
    return rand_word();
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    lookup_key  <= key;
    entry_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_table_op(op, key, value);
  endtask

  always @(posedge clk) begin : check_results
    table_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected beat: status %0d found_value %h entry_count %0d",
                 status, found_value, entry_count);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status);
            error_count++;
          end
          if (found_value !== exp_r.found_value) begin
            $error("found_value: expected %h, actual %h", exp_r.found_value, found_value);
            error_count++;
          end
          if (entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, entry_count);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_empty_table();
    send_beat(OP_GET, '0, '0);
    send_beat(OP_DELETE, ALL_ONES, ALL_ONES);
    send_beat(OP_UNUSED, ALL_ONES, ALL_ONES);
  endtask

  task automatic test_extreme_fields();
    send_beat(OP_ADD, '0, ALL_ONES);
    send_beat(OP_ADD, ALL_ONES, '0);
    send_beat(OP_ADD, {32{2'b01}}, {32{2'b10}});
    send_beat(OP_ADD, {32{2'b10}}, {32{2'b01}});
    send_beat(OP_GET, '0, ALL_ONES);
    send_beat(OP_GET, ALL_ONES, ALL_ONES);
    send_beat(OP_GET, {32{2'b01}}, '0);
    send_beat(OP_GET, {32{2'b10}}, '0);
    send_beat(OP_UNUSED, {32{2'b01}}, {32{2'b10}});
  endtask

  task automatic test_duplicate_keys();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    send_beat(OP_ADD, k, 64'd1);
    send_beat(OP_ADD, k, 64'd2);
    send_beat(OP_GET, k, '0);
    send_beat(OP_DELETE, k, '0);
    send_beat(OP_GET, k, '0);
    send_beat(OP_DELETE, k, '0);
    send_beat(OP_GET, k, '0);
    send_beat(OP_DELETE, k, '0);
  endtask

  task automatic test_random_traffic(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40) send_beat(OP_ADD, pick_key(), rand_word());
      else if (r < 65) send_beat(OP_DELETE, pick_key(), rand_word());
      else if (r < 95) send_beat(OP_GET, pick_key(), rand_word());
      else send_beat(OP_UNUSED, rand_word(), rand_word());
    end
  endtask

  task automatic test_fill_to_overflow();
    while (table_entries.size() < MAX_ENTRIES) begin
      if ($urandom_range(99) < 85) send_beat(OP_ADD, pick_key(), rand_word());
      else send_beat(OP_GET, pick_key(), rand_word());
    end
    repeat (3) send_beat(OP_ADD, pick_key(), rand_word());
    send_beat(OP_GET, pick_key(), rand_word());
    send_beat(OP_UNUSED, rand_word(), rand_word());
  endtask

  task automatic test_drain();
    int r;
    while (table_entries.size() > 0) begin
      r = $urandom_range(99);
      if (r < 75)
        send_beat(OP_DELETE, table_entries[$urandom_range(table_entries.size() - 1)].key,
                  rand_word());
      else if (r < 90) send_beat(OP_GET, pick_key(), rand_word());
      else send_beat(OP_DELETE, pick_key(), rand_word());
    end
    send_beat(OP_DELETE, pick_key(), rand_word());
    send_beat(OP_GET, pick_key(), rand_word());
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    test_random_traffic(30);
    test_fill_to_overflow();
    test_random_traffic(15);
    test_drain();
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_extreme_fields();
    test_duplicate_keys();
    run_random_phase(13, 77);
    run_random_phase(77, 13);
    run_random_phase(0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ keyed_table_insert_delete_lookup.f @@
+incdir+sv
sv/kt_pkg.sv
sv/kt_ram.sv
sv/keyed_table_insert_delete_lookup.sv
sv/kt_checker.sv
tb/keyed_table_insert_delete_lookup_test.sv
